// File: design/lzss_stream_encoder_unit_macros.svh
// assertion helpers for the encoder unit
`ifndef LZSS_STREAM_ENCODER_UNIT_MACROS_SVH
`define LZSS_STREAM_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define LZSS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lzss encoder check failed");

// next-cycle implication
`define LZSS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lzss encoder check failed");

`endif

// File: design/lzss_pkg.sv
package lzss_pkg;

   localparam int WINDOW_BITS = 6;
   localparam int LENGTH_BITS = 5;
   localparam int RING_SIZE   = 1 << WINDOW_BITS;
   localparam int LOOK_FULL   = (1 << LENGTH_BITS) + 1;
   localparam int LA          = (LOOK_FULL < RING_SIZE) ? LOOK_FULL : RING_SIZE;
   localparam int HIST        = RING_SIZE - LA;
   localparam int POS_W       = WINDOW_BITS;
   localparam int CNT_W       = $clog2(LA + 1);
   localparam int HIDX_W      = (HIST > 1) ? $clog2(HIST) : 1;
   localparam int MATCH_LEN_W = 1 + WINDOW_BITS + LENGTH_BITS;
   localparam int CODE_W      = (MATCH_LEN_W > 9) ? MATCH_LEN_W : 9;
   localparam int CLEN_W      = $clog2(CODE_W + 1);
   localparam int PK_W        = CODE_W + 8;
   localparam int NB_W        = $clog2(PK_W + 1);
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic emit;
   } pack_ctl_type;

endpackage

// File: design/lzss_if.sv
interface lzss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface lzss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, out_byte, out_last, input ready);
   modport sink (input valid, out_byte, out_last, output ready);
endinterface

// File: design/lzss_cell.sv
module lzss_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lzss_pkg::cell_ctl_type ctl,
   input  logic [7:0]            reset_byte,
   input  logic                  wr_en,
   input  logic [7:0]            wr_data,
   input  logic [7:0]            main_next,
   input  logic [7:0]            probe_next,
   input  logic [7:0]            key,
   output logic [7:0]            main_q,
   output logic [7:0]            probe_q,
   output logic                  hit
);

   logic [7:0] main_ff;
   logic [7:0] probe_ff;
   logic       alive_ff;

   assign hit     = alive_ff && (probe_ff == key);
   assign main_q  = main_ff;
   assign probe_q = probe_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         main_ff <= reset_byte;
      end else if (wr_en) begin
         main_ff <= wr_data;
      end else if (ctl.shift) begin
         main_ff <= main_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         probe_ff <= main_ff;
      end else if (ctl.step) begin
         probe_ff <= probe_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
      end else if (ctl.load) begin
         alive_ff <= 1'b1;
      end else if (ctl.step) begin
         alive_ff <= hit;
      end
   end

endmodule

// File: design/lzss_pack.sv
module lzss_pack (
   input  logic                         clock,
   input  logic                         reset,
   input  lzss_pkg::pack_ctl_type       ctl,
   input  logic [lzss_pkg::CODE_W-1:0]  code,
   input  logic [lzss_pkg::CLEN_W-1:0]  code_len,
   output logic [7:0]                   top_byte,
   output logic [lzss_pkg::NB_W-1:0]    nbits
);

   logic [lzss_pkg::PK_W-1:0] pk_ff, pk_in;
   logic [lzss_pkg::NB_W-1:0] n_ff, n_in;

   assign top_byte = pk_ff[lzss_pkg::PK_W-1 -: 8];
   assign nbits    = n_ff;

   always_comb begin
      pk_in = pk_ff;
      n_in  = n_ff;
      if (ctl.clear) begin
         pk_in = '0;
         n_in  = '0;
      end else if (ctl.load) begin
         pk_in = pk_ff | ({code, 8'h00} >> n_ff);
         n_in  = n_ff + lzss_pkg::NB_W'(code_len);
      end else if (ctl.emit) begin
         pk_in = pk_ff << 8;
         n_in  = (n_ff > lzss_pkg::NB_W'(8)) ? n_ff - lzss_pkg::NB_W'(8) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_ff <= '0;
         n_ff  <= '0;
      end else begin
         pk_ff <= pk_in;
         n_ff  <= n_in;
      end
   end

endmodule

// File: design/lzss_stream_encoder_unit.sv
// lzss stream encoder
// req_ch carries one input word per accepted byte (data_byte, last_byte);
// rsp_ch carries packed code bytes, first code bit in bit 7, out_last on
// the final byte of a compressed stream.
// bytes are stored in a rotating row of 64 cells (31 history, 33 lookahead).
// a byte that is not last and does not fill the lookahead leaves the block idle.
// a code passes a load state, a match state that tests one more byte per step
// until a miss or the end of the lookahead (up to 33 bytes), a pack state, an
// emit state that sends each output byte (1 or 2, up to 3 for the final code)
// and waits on a full output register, and a shift state per consumed byte (1 to 33).
// a last byte codes every pending byte the same way, flushes a zero-padded
// partial byte and then returns the block to its reset state.
// results sit in an output register; while the receiver stalls, the code
// engine waits on that register and req_ch.ready stays low until the engine
// is back in its idle state.
// reset (synchronous, active high) presets history to spaces, empties the
// lookahead and the bit packer and drops rsp_ch.valid.
`include "lzss_stream_encoder_unit_macros.svh"

module lzss_stream_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   lzss_req_if.sink   req_ch,
   lzss_rsp_if.source rsp_ch
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_MATCH = 3'd2;
   localparam logic [2:0] ST_PACK  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_SHIFT = 3'd5;

   localparam int RS = lzss_pkg::RING_SIZE;
   localparam int HI = lzss_pkg::HIST;
   localparam int CW = lzss_pkg::CNT_W;

   logic [2:0]                      state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [lzss_pkg::POS_W-1:0]      code_pos_ff, code_pos_in;
   logic                            eos_ff, eos_in;
   logic [CW-1:0]                   step_ff, step_in;
   logic [CW-1:0]                   best_len_ff, best_len_in;
   logic [lzss_pkg::HIDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [CW-1:0]                   shift_cnt_ff, shift_cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      rsp_byte_ff, rsp_byte_in;
   logic                            rsp_last_ff, rsp_last_in;

   lzss_pkg::cell_ctl_type          cell_ctl;
   lzss_pkg::pack_ctl_type          pack_ctl;
   logic [7:0]                      main_q  [RS];
   logic [7:0]                      probe_q [RS];
   logic [RS-1:0]                   hit;
   logic [RS-1:0]                   wr_en;
   logic [lzss_pkg::POS_W-1:0]      wr_idx;
   logic                            accept;
   logic                            any_hit;
   logic [lzss_pkg::HIDX_W-1:0]     hi_idx;
   logic [lzss_pkg::CODE_W-1:0]     code;
   logic [lzss_pkg::CLEN_W-1:0]     code_len;
   logic [7:0]                      top_byte;
   logic [lzss_pkg::NB_W-1:0]       nbits;
   logic                            literal;
   logic                            final_code;
   logic                            out_free;
   logic [lzss_pkg::POS_W-1:0]      match_pos;
   logic [CW-1:0]                   len_m2;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign accept          = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.out_last = rsp_last_ff;

   assign wr_idx = lzss_pkg::POS_W'(HI) + count_ff[lzss_pkg::POS_W-1:0];
   always_comb begin
      wr_en = '0;
      wr_en[wr_idx] = accept;
   end

   for (genvar k = 0; k < RS; k++) begin : g_cell
      localparam int NXT = (k + 1) % RS;
      lzss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .reset_byte ((k < HI) ? lzss_pkg::SPACE_CHAR : 8'h00),
         .wr_en      (wr_en[k]),
         .wr_data    (req_ch.data_byte),
         .main_next  (main_q[NXT]),
         .probe_next (probe_q[NXT]),
         .key        (probe_q[HI]),
         .main_q     (main_q[k]),
         .probe_q    (probe_q[k]),
         .hit        (hit[k])
      );
   end

   // nearest surviving candidate has the highest cell index
   always_comb begin
      any_hit = 1'b0;
      hi_idx  = '0;
      for (int i = 0; i < HI; i++) begin
         if (hit[i]) begin
            any_hit = 1'b1;
            hi_idx  = lzss_pkg::HIDX_W'(i);
         end
      end
   end

   assign literal    = (best_len_ff < CW'(2));
   assign match_pos  = code_pos_ff + lzss_pkg::POS_W'(best_idx_ff) - lzss_pkg::POS_W'(HI);
   assign len_m2     = best_len_ff - CW'(2);
   assign final_code = eos_ff && (count_ff == '0);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (literal) begin
         code     = lzss_pkg::CODE_W'({1'b1, main_q[HI]}) << (lzss_pkg::CODE_W - 9);
         code_len = lzss_pkg::CLEN_W'(9);
      end else begin
         code     = lzss_pkg::CODE_W'({1'b0, match_pos, len_m2[lzss_pkg::LENGTH_BITS-1:0]})
                    << (lzss_pkg::CODE_W - lzss_pkg::MATCH_LEN_W);
         code_len = lzss_pkg::CLEN_W'(lzss_pkg::MATCH_LEN_W);
      end
   end

   lzss_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pack_ctl),
      .code     (code),
      .code_len (code_len),
      .top_byte (top_byte),
      .nbits    (nbits)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      code_pos_in  = code_pos_ff;
      eos_in       = eos_ff;
      step_in      = step_ff;
      best_len_in  = best_len_ff;
      best_idx_in  = best_idx_ff;
      shift_cnt_in = shift_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      cell_ctl     = '0;
      pack_ctl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = count_ff + CW'(1);
               if (req_ch.last_byte) begin
                  eos_in   = 1'b1;
                  state_in = ST_LOAD;
               end else if (count_ff + CW'(1) == CW'(lzss_pkg::LA)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cell_ctl.load = 1'b1;
            step_in       = '0;
            best_len_in   = CW'(1);
            best_idx_in   = '0;
            state_in      = ST_MATCH;
         end
         ST_MATCH: begin
            cell_ctl.step = 1'b1;
            if (any_hit) begin
               best_len_in = step_ff + CW'(1);
               best_idx_in = hi_idx;
            end
            if (!any_hit || (step_ff + CW'(1) == count_ff)) begin
               state_in = ST_PACK;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_PACK: begin
            pack_ctl.load = 1'b1;
            count_in      = count_ff - best_len_ff;
            shift_cnt_in  = best_len_ff;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if ((nbits >= lzss_pkg::NB_W'(8)) || (final_code && (nbits != '0))) begin
               if (out_free) begin
                  pack_ctl.emit = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = top_byte;
                  rsp_last_in   = final_code && (nbits <= lzss_pkg::NB_W'(8));
               end
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cell_ctl.shift = 1'b1;
            code_pos_in    = code_pos_ff + lzss_pkg::POS_W'(1);
            shift_cnt_in   = shift_cnt_ff - CW'(1);
            if (shift_cnt_ff == CW'(1)) begin
               if (final_code) begin
                  cell_ctl.clear = 1'b1;
                  pack_ctl.clear = 1'b1;
                  code_pos_in    = lzss_pkg::POS_W'(HI);
                  eos_in         = 1'b0;
                  state_in       = ST_IDLE;
               end else if (eos_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         code_pos_ff  <= lzss_pkg::POS_W'(HI);
         eos_ff       <= 1'b0;
         step_ff      <= '0;
         best_len_ff  <= CW'(1);
         best_idx_ff  <= '0;
         shift_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         code_pos_ff  <= code_pos_in;
         eos_ff       <= eos_in;
         step_ff      <= step_in;
         best_len_ff  <= best_len_in;
         best_idx_ff  <= best_idx_in;
         shift_cnt_ff <= shift_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   `LZSS_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CW'(lzss_pkg::LA))
   `LZSS_ASSERT_IMP(a_match_bound, state_ff == ST_MATCH, step_ff < count_ff)
   `LZSS_ASSERT_NXT(a_stream_end,
      (state_ff == ST_SHIFT) && (shift_cnt_ff == CW'(1)) && final_code,
      (state_ff == ST_IDLE) && (count_ff == '0) && !eos_ff)

endmodule
